FILE: sv/bdem_pkg.sv
package bdem_pkg;

  // default sizes of the tables
  localparam int SEGMENTS_DEF = 16;
  localparam int PORTS_DEF    = 16;
  localparam int RESV_DEF     = 8;

  // field widths
  localparam int OP_W    = 3;
  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 2;
  localparam int ID_W    = 8;
  localparam int PORT_W  = 4;
  localparam int ENTRY_W = 4;
  localparam int ACT_W   = 5;

  // request codes
  localparam logic [OP_W-1:0] OP_LOAD_SEG = 3'd0;
  localparam logic [OP_W-1:0] OP_READ     = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd2;
  localparam logic [OP_W-1:0] OP_LL       = 3'd3;
  localparam logic [OP_W-1:0] OP_SC       = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [SIZE_W-1:0]  access_size;
    logic [ID_W-1:0]    master_id;
    logic [PORT_W-1:0]  target_port;
    logic [ENTRY_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic               fwd_valid;
    logic               fwd_write;
    logic [PORT_W-1:0]  fwd_port;
    logic [ADDR_W-1:0]  fwd_addr;
    logic [DATA_W-1:0]  fwd_data;
    logic [SIZE_W-1:0]  fwd_size;
    logic               decode_error;
    logic               sc_failed;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
    logic [PORT_W-1:0] port;
  } seg_entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   owner;
  } resv_entry_t;

  // flags from the shared address comparator
  typedef struct packed {
    logic below;
    logic above;
    logic equal;
  } cmp_res_t;

endpackage

FILE: sv/bdem_seg_table.sv
module bdem_seg_table import bdem_pkg::*; #(
  parameter int SEGMENTS = SEGMENTS_DEF,
  localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  seg_entry_t    wr_entry,
  input  logic [IW-1:0] rd_idx,
  output seg_entry_t    rd_entry
);

  seg_entry_t mem [SEGMENTS];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_entry <= mem[rd_idx];
  end

endmodule

FILE: sv/bdem_resv_table.sv
module bdem_resv_table import bdem_pkg::*; #(
  parameter int RESERVATIONS = RESV_DEF,
  localparam int RW = (RESERVATIONS > 1) ? $clog2(RESERVATIONS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic                    clr_en,
  input  logic [RW-1:0]           wr_idx,
  input  resv_entry_t             wr_entry,
  input  logic [RW-1:0]           rd_idx,
  output resv_entry_t             rd_entry,
  output logic [RESERVATIONS-1:0] valid
);

  resv_entry_t mem [RESERVATIONS];

  // reservation storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_entry <= mem[rd_idx];
  end

  // valid flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end else if (clr_en) begin
      valid[wr_idx] <= 1'b0;
    end
  end

endmodule

FILE: sv/bdem_cmp.sv
module bdem_cmp import bdem_pkg::*; (
  input  logic [ADDR_W-1:0] key,
  input  logic [ADDR_W-1:0] lo_bound,
  input  logic [ADDR_W-1:0] hi_bound,
  output cmp_res_t          res
);

  // address against a range, and equality against the low bound
  always_comb begin
    res.below = key < lo_bound;
    res.above = key > hi_bound;
    res.equal = key == lo_bound;
  end

endmodule

FILE: sv/bus_decode_exclusive_monitor_unit.sv
// channel   signals                          payload
// req       req_valid / req_ready            req   (req_t)
// rsp       rsp_valid / rsp_ready            rsp   (rsp_t)
// cfg       cfg_wr_en, cfg_wr_data           active_segments, no read-back
//
// a segment load or unknown code goes straight to the result; read and write first
// binary search the segment table, one probe per table read (one table read a cycle)
// after a segment hit, load-linked and store-conditional then scan the reservation
// table one entry a cycle through the same comparator
// the next request is taken once the result sits in the output register
// rst is synchronous; it clears reservations, the victim pointer and the register
module bus_decode_exclusive_monitor_unit import bdem_pkg::*; #(
  parameter int SEGMENTS     = SEGMENTS_DEF,
  parameter int PORTS        = PORTS_DEF,
  parameter int RESERVATIONS = RESV_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [ACT_W-1:0] cfg_wr_data,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  localparam int IW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CW  = $clog2(SEGMENTS + 1);
  localparam int RW  = (RESERVATIONS > 1) ? $clog2(RESERVATIONS) : 1;
  localparam int RCW = $clog2(RESERVATIONS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_SCAN, ST_DONE} state_t;

  state_t             state;
  logic [ACT_W-1:0]   active_segments;
  req_t               cur;
  rsp_t               res;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hn;
  logic [IW-1:0]      mid;
  logic [PORT_W-1:0]  slot_port;
  logic [RCW-1:0]     scan_cnt;
  logic               cmp_pend;
  logic [RW-1:0]      cmp_idx;
  logic               free_found;
  logic [RW-1:0]      free_idx;
  logic [RW-1:0]      victim;

  logic               accept;
  logic [CW-1:0]      seg_count;
  logic [8:0]         load_idx9;
  logic               seg_wr_en;
  seg_entry_t         seg_wr_entry;
  seg_entry_t         seg_rd;
  logic [CW-1:0]      lo_nx;
  logic [CW-1:0]      hn_nx;
  logic [CW:0]        mid_sum;
  logic [IW-1:0]      mid_nx;
  logic               search_more;
  logic [ADDR_W-1:0]  cmp_lo;
  logic [ADDR_W-1:0]  cmp_hi;
  cmp_res_t           cmp_res;
  logic               seg_hit;
  logic [RW-1:0]      scan_idx;
  logic               scan_match;
  logic               scan_end;
  logic               owner_ok;
  logic               resv_wr_en;
  logic               resv_clr_en;
  logic [RW-1:0]      resv_wr_idx;
  resv_entry_t        resv_wr_entry;
  resv_entry_t        resv_rd;
  logic [RESERVATIONS-1:0] resv_valid;

  // forwarded result for the current request
  function automatic rsp_t fwd_rsp(input req_t r, input logic [PORT_W-1:0] port);
    rsp_t o;
    o              = '0;
    o.fwd_valid    = 1'b1;
    o.fwd_write    = (r.op == OP_WRITE) || (r.op == OP_SC);
    o.fwd_port     = port;
    o.fwd_addr     = r.addr;
    o.fwd_data     = o.fwd_write ? r.data : '0;
    o.fwd_size     = r.access_size;
    return o;
  endfunction

  // decode miss result
  function automatic rsp_t miss_rsp(input logic [OP_W-1:0] op);
    rsp_t o;
    o              = '0;
    o.decode_error = 1'b1;
    o.sc_failed    = (op == OP_SC);
    return o;
  endfunction

  // store-conditional refused for lack of a matching reservation owned by its master
  function automatic rsp_t refused_rsp();
    rsp_t o;
    o           = '0;
    o.sc_failed = 1'b1;
    return o;
  endfunction

  // handshake and segment load
  always_comb begin
    req_ready = (state == ST_IDLE);
    accept    = req_valid && req_ready;
    if (9'(active_segments) >= 9'(SEGMENTS)) begin
      seg_count = CW'(SEGMENTS);
    end else begin
      seg_count = CW'(active_segments);
    end
    load_idx9          = 9'(req.entry_index);
    seg_wr_en          = accept && (req.op == OP_LOAD_SEG) &&
                         (load_idx9 < 9'(SEGMENTS)) &&
                         (7'(req.target_port) < 7'(PORTS));
    seg_wr_entry.base  = req.addr;
    seg_wr_entry.limit = req.data;
    seg_wr_entry.port  = req.target_port;
  end

  // shared comparator operands
  always_comb begin
    if (state == ST_SCAN) begin
      cmp_lo = resv_rd.addr;
      cmp_hi = resv_rd.addr;
    end else begin
      cmp_lo = seg_rd.base;
      cmp_hi = seg_rd.limit;
    end
  end

  bdem_cmp u_cmp (
    .key      (cur.addr),
    .lo_bound (cmp_lo),
    .hi_bound (cmp_hi),
    .res      (cmp_res)
  );

  // binary search step: narrow the bounds and pick the next probe
  always_comb begin
    seg_hit = !cmp_res.below && !cmp_res.above;
    lo_nx   = lo;
    hn_nx   = hn;
    if (state == ST_IDLE) begin
      lo_nx = '0;
      hn_nx = seg_count;
    end else if (cmp_res.below) begin
      hn_nx = CW'(mid);
    end else begin
      lo_nx = CW'(mid) + CW'(1);
    end
    mid_sum     = (CW+1)'(lo_nx) + (CW+1)'(hn_nx) - (CW+1)'(1);
    mid_nx      = IW'(mid_sum[CW:1]);
    search_more = lo_nx < hn_nx;
  end

  bdem_seg_table #(.SEGMENTS(SEGMENTS)) u_seg (
    .clk      (clk),
    .wr_en    (seg_wr_en),
    .wr_idx   (load_idx9[IW-1:0]),
    .wr_entry (seg_wr_entry),
    .rd_idx   (mid_nx),
    .rd_entry (seg_rd)
  );

  // reservation scan and update
  always_comb begin
    scan_idx   = scan_cnt[RW-1:0];
    scan_match = cmp_pend && resv_valid[cmp_idx] && cmp_res.equal;
    scan_end   = scan_match || (scan_cnt == RCW'(RESERVATIONS));
    owner_ok   = resv_rd.owner == cur.master_id;

    resv_wr_en          = (state == ST_SCAN) && scan_end && (cur.op == OP_LL);
    resv_clr_en         = (state == ST_SCAN) && scan_match && owner_ok &&
                          (cur.op == OP_SC);
    resv_wr_entry.addr  = cur.addr;
    resv_wr_entry.owner = cur.master_id;
    if (scan_match) begin
      resv_wr_idx = cmp_idx;
    end else if (free_found) begin
      resv_wr_idx = free_idx;
    end else begin
      resv_wr_idx = victim;
    end
  end

  bdem_resv_table #(.RESERVATIONS(RESERVATIONS)) u_resv (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (resv_wr_en),
    .clr_en   (resv_clr_en),
    .wr_idx   (resv_wr_idx),
    .wr_entry (resv_wr_entry),
    .rd_idx   (scan_idx),
    .rd_entry (resv_rd),
    .valid    (resv_valid)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      active_segments <= '0;
      victim          <= '0;
      rsp_valid       <= 1'b0;
      cmp_pend        <= 1'b0;
      free_found      <= 1'b0;
      scan_cnt        <= '0;
    end else begin
      if (cfg_wr_en) begin
        active_segments <= cfg_wr_data;
      end
      if (rsp_valid && rsp_ready && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur <= req;
            lo  <= lo_nx;
            hn  <= hn_nx;
            mid <= mid_nx;
            case (req.op) inside
              OP_READ, OP_WRITE, OP_LL, OP_SC: begin
                if (search_more) begin
                  state <= ST_SEARCH;
                end else begin
                  res   <= miss_rsp(req.op);
                  state <= ST_DONE;
                end
              end
              default: begin
                res   <= '0;
                state <= ST_DONE;
              end
            endcase
          end
        end

        ST_SEARCH: begin
          if (seg_hit) begin
            slot_port <= seg_rd.port;
            if ((cur.op == OP_LL) || (cur.op == OP_SC)) begin
              scan_cnt   <= '0;
              cmp_pend   <= 1'b0;
              free_found <= 1'b0;
              state      <= ST_SCAN;
            end else begin
              res   <= fwd_rsp(cur, seg_rd.port);
              state <= ST_DONE;
            end
          end else if (search_more) begin
            lo  <= lo_nx;
            hn  <= hn_nx;
            mid <= mid_nx;
          end else begin
            res   <= miss_rsp(cur.op);
            state <= ST_DONE;
          end
        end

        ST_SCAN: begin
          if (scan_end) begin
            cmp_pend <= 1'b0;
            if (cur.op == OP_LL) begin
              res <= fwd_rsp(cur, slot_port);
              if (!scan_match && !free_found) begin
                if (victim == RW'(RESERVATIONS - 1)) begin
                  victim <= '0;
                end else begin
                  victim <= victim + RW'(1);
                end
              end
            end else if (scan_match && owner_ok) begin
              res <= fwd_rsp(cur, slot_port);
            end else begin
              res <= refused_rsp();
            end
            state <= ST_DONE;
          end else begin
            cmp_pend <= 1'b1;
            cmp_idx  <= scan_idx;
            scan_cnt <= scan_cnt + RCW'(1);
            if (!free_found && !resv_valid[scan_idx]) begin
              free_found <= 1'b1;
              free_idx   <= scan_idx;
            end
          end
        end

        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
